// ===== sv/bba_pkg.sv =====
// Shared types and constants of the bitmap block allocator.
// Used by the top level, the sequencer and the testbench; depends on nothing.

package bba_pkg;

  localparam int DEF_NUM_BLOCKS    = 1024;
  localparam int DEF_MAP_WORD_BITS = 32;
  localparam int RESERVED_RESET    = 10;

  localparam int INDEX_W   = 16;
  localparam int RESERVE_W = 11;
  localparam int GRANT_W   = 10;
  localparam int FREE_W    = 11;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_MARK   = 2'd2,
    OP_FORMAT = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_IGNORED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_MODIFY,
    S_RESP
  } state_t;

  typedef struct packed {
    status_t              status;
    logic [GRANT_W-1:0]   granted_block;
    logic [FREE_W-1:0]    free_count;
  } result_t;

endpackage

// ===== sv/block_bitmap_allocator_unit.sv =====
// Top level of the first-fit bitmap block allocator.
// Depends on bba_pkg, bba_map_ram and bba_seq.
//
// Usage: one beat on the in_ channel is one operation (in_tuser = op,
// in_tdata = block number); every operation returns exactly one beat on
// the out_ channel with the status in out_tuser and the granted block and
// free count in out_tdata. cfg_ sets the number of blocks reserved by format
// and is always ready. The map sits in a memory of MAP_WORD_BITS-bit words;
// operations run one at a time, free, mark and allocate as a read, modify
// and write of that memory, and in_tready returns in the cycle after the
// sequencer hands its result on. An out-of-range request or an allocate on
// a full map is answered without touching the memory; an allocate scans
// upward from map word 0 (the scan reads one word per cycle, at most
// MAP_WORDS = 32 by default), and format rewrites every word.
// After reset the block runs the same rewrite pass (reserving the low 10
// blocks) with in_tready low.
// The output register frees the sequencer: the next beat is accepted while
// a result waits; if the receiver stalls, the following result waits in the
// sequencer and in_tready stays low until the output register drains.

module block_bitmap_allocator_unit
  import bba_pkg::*;
#(
  parameter int NUM_BLOCKS    = DEF_NUM_BLOCKS,
  parameter int MAP_WORD_BITS = DEF_MAP_WORD_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [15:0]          in_tdata,   // [15:0] blk_num
  input  logic [1:0]           in_tuser,   // [1:0] op
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [23:0]          out_tdata,  // [9:0] granted_block, [20:10] free_count
  output logic [1:0]           out_tuser,  // [1:0] status
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [RESERVE_W-1:0] cfg_data    // reserved_blocks
);

  localparam int MAP_WORDS = (NUM_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

  logic [RESERVE_W-1:0]     reserved_r;
  logic                     out_valid_r;
  result_t                  out_res_r;

  logic                     res_valid;
  logic                     res_ready;
  result_t                  res;
  logic                     ram_re;
  logic [AW-1:0]            ram_raddr;
  logic [MAP_WORD_BITS-1:0] ram_rdata;
  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [MAP_WORD_BITS-1:0] ram_wdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reserved_r <= RESERVE_W'(RESERVED_RESET);
    end else if (cfg_valid) begin
      reserved_r <= cfg_data;
    end
  end

  bba_map_ram #(
    .DEPTH (MAP_WORDS),
    .WIDTH (MAP_WORD_BITS),
    .AW    (AW)
  ) u_map_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bba_seq #(
    .NUM_BLOCKS    (NUM_BLOCKS),
    .MAP_WORD_BITS (MAP_WORD_BITS),
    .MAP_WORDS     (MAP_WORDS),
    .AW            (AW)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_op        (op_t'(in_tuser)),
    .in_index     (in_tdata),
    .cfg_reserved (reserved_r),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .ram_re       (ram_re),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata)
  );

  // Output register takes a new result whenever it is empty or draining.
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {3'b000, out_res_r.free_count, out_res_r.granted_block};

endmodule

// ===== sv/bba_map_ram.sv =====
// Usage map storage: one write port, one read port, registered read data.
// Depends on nothing but its parameters.

module bba_map_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32,
  parameter int AW    = 5
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/bba_first_free.sv =====
// Finds the lowest clear bit of one map word.
// Depends on nothing but its parameters.

module bba_first_free #(
  parameter int WIDTH = 32,
  parameter int BIT_W = 5
) (
  input  logic [WIDTH-1:0] word,
  output logic             found,
  output logic [BIT_W-1:0] pos
);

  always_comb begin
    found = 1'b0;
    pos   = '0;
    // Walking down from the top leaves the lowest clear bit in pos.
    for (int i = WIDTH - 1; i >= 0; i--) begin
      if (!word[i]) begin
        found = 1'b1;
        pos   = BIT_W'(i);
      end
    end
  end

endmodule

// ===== sv/bba_seq.sv =====
// Operation sequencer: read-modify-write of the usage map, free counter,
// format sweep. Depends on bba_pkg and bba_first_free.

module bba_seq
  import bba_pkg::*;
#(
  parameter int NUM_BLOCKS    = DEF_NUM_BLOCKS,
  parameter int MAP_WORD_BITS = DEF_MAP_WORD_BITS,
  parameter int MAP_WORDS     = (NUM_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS,
  parameter int AW            = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  op_t                      in_op,
  input  logic [INDEX_W-1:0]       in_index,
  input  logic [RESERVE_W-1:0]     cfg_reserved,
  output logic                     res_valid,
  input  logic                     res_ready,
  output result_t                  res,
  output logic                     ram_re,
  output logic [AW-1:0]            ram_raddr,
  input  logic [MAP_WORD_BITS-1:0] ram_rdata,
  output logic                     ram_we,
  output logic [AW-1:0]            ram_waddr,
  output logic [MAP_WORD_BITS-1:0] ram_wdata
);

  localparam int BIT_W     = $clog2(MAP_WORD_BITS);
  localparam int CNT_W     = $clog2(NUM_BLOCKS + 1);
  localparam int TAIL_BITS = MAP_WORDS * MAP_WORD_BITS - NUM_BLOCKS;
  localparam logic [MAP_WORD_BITS-1:0] TAIL_MASK = ~({MAP_WORD_BITS{1'b1}} >> TAIL_BITS);

  state_t             state_r, state_nxt;
  logic [AW-1:0]      addr_r, addr_nxt;
  logic [BIT_W-1:0]   bit_r, bit_nxt;
  op_t                op_r, op_nxt;
  logic               fmt_resp_r, fmt_resp_nxt;
  logic [CNT_W-1:0]   reserve_r, reserve_nxt;
  logic [CNT_W-1:0]   free_r, free_nxt;
  result_t            res_r, res_nxt;

  logic               hit_found;
  logic [BIT_W-1:0]   hit_pos;
  logic               idx_out_range;
  logic               last_word;
  logic               cur_used;

  bba_first_free #(
    .WIDTH (MAP_WORD_BITS),
    .BIT_W (BIT_W)
  ) u_first_free (
    .word  (ram_rdata),
    .found (hit_found),
    .pos   (hit_pos)
  );

  assign idx_out_range = int'(in_index) >= NUM_BLOCKS;
  assign last_word     = int'(addr_r) == MAP_WORDS - 1;
  assign cur_used      = ram_rdata[bit_r];

  assign in_ready  = state_r == S_IDLE;
  assign res_valid = state_r == S_RESP;
  assign res       = res_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (last_word) begin
          state_nxt = fmt_resp_r ? S_RESP : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_op)
            OP_ALLOC:  state_nxt = (free_r == '0) ? S_RESP : S_SCAN;
            OP_FREE,
            OP_MARK:   state_nxt = idx_out_range ? S_RESP : S_MODIFY;
            OP_FORMAT: state_nxt = S_CLEAR;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (hit_found) begin
          state_nxt = S_RESP;
        end
      end
      S_MODIFY: state_nxt = S_RESP;
      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    int                       base;
    int                       rem;
    logic [MAP_WORD_BITS-1:0] fill;

    addr_nxt     = addr_r;
    bit_nxt      = bit_r;
    op_nxt       = op_r;
    fmt_resp_nxt = fmt_resp_r;
    reserve_nxt  = reserve_r;
    free_nxt     = free_r;
    res_nxt      = res_r;
    ram_re       = 1'b0;
    ram_raddr    = addr_r;
    ram_we       = 1'b0;
    ram_waddr    = addr_r;
    ram_wdata    = ram_rdata;

    // Reserved bits of the word the sweep is on.
    base = int'(addr_r) << BIT_W;
    rem  = int'(reserve_r) - base;
    if (rem >= MAP_WORD_BITS) begin
      fill = '1;
    end else if (rem <= 0) begin
      fill = '0;
    end else begin
      fill = ~({MAP_WORD_BITS{1'b1}} << rem[BIT_W-1:0]);
    end

    unique case (state_r)
      S_CLEAR: begin
        // Blocks past the end of the map are kept permanently used.
        ram_we    = 1'b1;
        ram_wdata = last_word ? (fill | TAIL_MASK) : fill;
        addr_nxt  = addr_r + AW'(1);
        if (last_word) begin
          addr_nxt              = '0;
          free_nxt              = CNT_W'(NUM_BLOCKS) - reserve_r;
          res_nxt.status        = STAT_DONE;
          res_nxt.granted_block = '0;
          res_nxt.free_count    = FREE_W'(free_nxt);
        end
      end
      S_IDLE: begin
        res_nxt.granted_block = '0;
        res_nxt.free_count    = FREE_W'(free_r);
        if (in_valid) begin
          op_nxt = in_op;
          unique case (in_op)
            OP_ALLOC: begin
              res_nxt.status = STAT_FULL;
              if (free_r != '0) begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                addr_nxt  = '0;
              end
            end
            OP_FREE,
            OP_MARK: begin
              res_nxt.status = STAT_IGNORED;
              if (!idx_out_range) begin
                ram_re    = 1'b1;
                ram_raddr = AW'(in_index >> BIT_W);
                addr_nxt  = AW'(in_index >> BIT_W);
                bit_nxt   = in_index[BIT_W-1:0];
              end
            end
            OP_FORMAT: begin
              addr_nxt     = '0;
              fmt_resp_nxt = 1'b1;
              if (int'(cfg_reserved) > NUM_BLOCKS) begin
                reserve_nxt = CNT_W'(NUM_BLOCKS);
              end else begin
                reserve_nxt = CNT_W'(cfg_reserved);
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (hit_found) begin
          ram_we                = 1'b1;
          ram_wdata             = ram_rdata | (MAP_WORD_BITS'(1) << hit_pos);
          free_nxt              = free_r - CNT_W'(1);
          res_nxt.status        = STAT_DONE;
          res_nxt.granted_block = GRANT_W'({addr_r, hit_pos});
          res_nxt.free_count    = FREE_W'(free_nxt);
        end else begin
          ram_re    = 1'b1;
          ram_raddr = addr_r + AW'(1);
          addr_nxt  = addr_r + AW'(1);
        end
      end
      S_MODIFY: begin
        res_nxt.status = STAT_IGNORED;
        if (op_r == OP_FREE && cur_used) begin
          ram_we         = 1'b1;
          ram_wdata      = ram_rdata & ~(MAP_WORD_BITS'(1) << bit_r);
          free_nxt       = free_r + CNT_W'(1);
          res_nxt.status = STAT_DONE;
        end else if (op_r == OP_MARK && !cur_used) begin
          ram_we         = 1'b1;
          ram_wdata      = ram_rdata | (MAP_WORD_BITS'(1) << bit_r);
          free_nxt       = free_r - CNT_W'(1);
          res_nxt.status = STAT_DONE;
        end
        res_nxt.free_count = FREE_W'(free_nxt);
      end
      S_RESP: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      addr_r     <= '0;
      fmt_resp_r <= 1'b0;
      reserve_r  <= CNT_W'(RESERVED_RESET);
      free_r     <= CNT_W'(NUM_BLOCKS - RESERVED_RESET);
      op_r       <= OP_ALLOC;
    end else begin
      state_r    <= state_nxt;
      addr_r     <= addr_nxt;
      fmt_resp_r <= fmt_resp_nxt;
      reserve_r  <= reserve_nxt;
      free_r     <= free_nxt;
      op_r       <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bit_r <= bit_nxt;
    res_r <= res_nxt;
  end

`ifndef SYNTHESIS
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(free_r) <= NUM_BLOCKS)
    else $error("free counter above block count");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> free_r != '0)
    else $error("scan running with no free block");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_CLEAR || state_r == S_SCAN || state_r == S_MODIFY))
    else $error("map written outside an update");

  a_full_resp: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_op == OP_ALLOC && free_r == '0)
      |=> (state_r == S_RESP && res_r.status == STAT_FULL))
    else $error("allocate on a full map not reported");
`endif

endmodule

// ===== tb/tb_block_bitmap_allocator_unit.sv =====
// Testbench of block_bitmap_allocator_unit: a usage-map tracker predicts each result beat
// and checks the out_ beats in order while random gaps and stalls hit both channels.
// Depends on bba_pkg and the allocator RTL.

import bba_pkg::*;

class block_map_tracker;
  bit [DEF_NUM_BLOCKS-1:0] used_map;
  int unsigned             free_total;
  logic [RESERVE_W-1:0]    reserve_cfg;
  result_t                 expected_results[$];
  int unsigned             errors;

  function new();
    reserve_cfg = RESERVE_W'(RESERVED_RESET);
    errors = 0;
    format_map();
  endfunction

  function void set_reserve(logic [RESERVE_W-1:0] value);
    reserve_cfg = value;
  endfunction

  // Reservations beyond the map size saturate, leaving no free block.
  function void format_map();
    int unsigned n;
    int i;
    n = (reserve_cfg > DEF_NUM_BLOCKS) ? DEF_NUM_BLOCKS : reserve_cfg;
    used_map = '0;
    for (i = 0; i < n; i++) used_map[i] = 1'b1;
    free_total = DEF_NUM_BLOCKS - n;
  endfunction

  function result_t predict_op(op_t op, logic [INDEX_W-1:0] idx);
    result_t r;
    int i;
    r.status = STAT_DONE;
    r.granted_block = '0;
    case (op)
      OP_ALLOC: begin
        i = 0;
        while (i < DEF_NUM_BLOCKS && used_map[i]) i++;
        if (i < DEF_NUM_BLOCKS) begin
          used_map[i] = 1'b1;
          free_total--;
          r.granted_block = GRANT_W'(i);
        end else begin
          r.status = STAT_FULL;
        end
      end
      OP_FREE, OP_MARK: begin
        if (idx >= DEF_NUM_BLOCKS) begin
          r.status = STAT_IGNORED;
        end else if (used_map[idx] == (op == OP_MARK)) begin
          r.status = STAT_IGNORED;
        end else begin
          used_map[idx] = (op == OP_MARK);
          if (op == OP_MARK) free_total--;
          else free_total++;
        end
      end
      default: format_map();
    endcase
    r.free_count = FREE_W'(free_total);
    return r;
  endfunction

  function void note_op(op_t op, logic [INDEX_W-1:0] idx);
    expected_results.push_back(predict_op(op, idx));
  endfunction

  function void check_result(logic [1:0] st, logic [GRANT_W-1:0] g, logic [FREE_W-1:0] f);
    result_t e;
    if (expected_results.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result beat: status %0d block %0d free %0d", st, g, f);
      return;
    end
    e = expected_results.pop_front();
    if (st !== e.status || g !== e.granted_block || f !== e.free_count) begin
      errors++;
      if (errors <= 10)
        $display("result mismatch: expected status %0d block %0d free %0d, got %0d %0d %0d",
                 e.status, e.granted_block, e.free_count, st, g, f);
    end
  endfunction

  // Returns a block in the wanted state, or -1 when there is none.
  function int pick_block(bit want_used);
    int i;
    int start;
    for (i = 0; i < 40; i++) begin
      start = $urandom_range(0, DEF_NUM_BLOCKS - 1);
      if (used_map[start] == want_used) return start;
    end
    start = $urandom_range(0, DEF_NUM_BLOCKS - 1);
    for (i = 0; i < DEF_NUM_BLOCKS; i++)
      if (used_map[(start + i) % DEF_NUM_BLOCKS] == want_used)
        return (start + i) % DEF_NUM_BLOCKS;
    return -1;
  endfunction
endclass

module tb_block_bitmap_allocator_unit;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [15:0]          in_tdata;
  logic [1:0]           in_tuser;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [23:0]          out_tdata;
  logic [1:0]           out_tuser;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [RESERVE_W-1:0] cfg_data;

  block_map_tracker book = new();
  int tx_calm = 0;
  int rx_calm = 0;
  bit hold_req = 1'b0;

  block_bitmap_allocator_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("== FAIL ==");
    $finish;
  end

  // Draws a random wait, zero during occasional stretches of back-to-back beats.
  function automatic int draw_wait(ref int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(10, 40);
    return $urandom_range(0, 13);
  endfunction

  // Result side: check every accepted beat, then stall for a drawn number of cycles.
  initial begin
    int n;
    out_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        book.check_result(out_tuser, out_tdata[9:0], out_tdata[20:10]);
        n = draw_wait(rx_calm);
        if (hold_req) begin
          hold_req = 1'b0;
          n = 300;
        end
        if (n > 0) begin
          out_tready <= 1'b0;
          repeat (n) @(posedge clk);
          out_tready <= 1'b1;
        end
      end
    end
  end

  // in_tvalid stays high after a beat so that a zero gap gives back-to-back beats.
  task automatic send_op(op_t op, logic [INDEX_W-1:0] idx);
    int gap;
    gap = draw_wait(tx_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= idx;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    book.note_op(op, idx);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (book.expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reserve(logic [RESERVE_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    book.set_reserve(value);
  endtask

  task automatic run_random(int n);
    int k;
    int r;
    int b;
    op_t op;
    logic [INDEX_W-1:0] idx;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      idx = INDEX_W'($urandom);
      if (r < 40) begin
        op = OP_ALLOC;
      end else if (r < 77) begin
        op = (r < 62) ? OP_FREE : OP_MARK;
        b = book.pick_block(op == OP_FREE);
        if (b >= 0) idx = INDEX_W'(b);
      end else if (r < 92) begin
        // Raw index, mostly beyond the map.
        op = $urandom_range(0, 1) ? OP_FREE : OP_MARK;
      end else if (r < 96) begin
        // Request that would not change the bit.
        op = $urandom_range(0, 1) ? OP_FREE : OP_MARK;
        b = book.pick_block(op == OP_MARK);
        if (b >= 0) idx = INDEX_W'(b);
      end else begin
        op = OP_FORMAT;
      end
      send_op(op, idx);
    end
  endtask

  initial begin
    int unsigned reserve_steps [8];
    int p;
    reserve_steps = '{0, 2047, 1023, 700, 990, 0, 10, 1024};
    reserve_steps[5] = $urandom_range(0, 2047);
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= OP_ALLOC;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);

    // Map as left by reset: low ten blocks reserved.
    send_op(OP_ALLOC, 16'hFFFF);
    send_op(OP_FREE, 16'd10);
    send_op(OP_FREE, 16'd10);
    send_op(OP_MARK, 16'd1023);
    send_op(OP_MARK, 16'd1023);
    send_op(OP_FREE, 16'd1024);
    send_op(OP_MARK, 16'hFFFF);
    send_op(OP_FREE, 16'd0);
    send_op(OP_ALLOC, 16'd0);
    send_op(OP_FORMAT, 16'hAAAA);

    // Full map: allocate must report no free block.
    drain_results();
    write_reserve(11'd1024);
    send_op(OP_FORMAT, 16'h5555);
    send_op(OP_ALLOC, 16'd0);
    send_op(OP_FREE, 16'd1023);
    send_op(OP_ALLOC, 16'd0);
    send_op(OP_ALLOC, 16'd0);
    send_op(OP_MARK, 16'd5);

    // Reservation above the map size saturates.
    drain_results();
    write_reserve(11'h7FF);
    send_op(OP_FORMAT, 16'd0);
    send_op(OP_FREE, 16'd1023);
    send_op(OP_ALLOC, 16'd0);

    drain_results();
    write_reserve(11'd0);
    send_op(OP_FORMAT, 16'd0);
    send_op(OP_ALLOC, 16'd0);
    send_op(OP_FREE, 16'd512);

    for (p = 0; p < 8; p++) begin
      drain_results();
      write_reserve(RESERVE_W'(reserve_steps[p]));
      if (p == 1) begin
        // Long receiver hold while the sender keeps offering beats.
        hold_req = 1'b1;
        tx_calm = 60;
      end
      send_op(OP_FORMAT, INDEX_W'($urandom));
      if (p == 3) begin
        run_random(55);
        drain_results();
        run_random(55);
      end else begin
        run_random(110);
      end
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (book.errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
